[rtl/rld_pkg.sv]
package rld_pkg;

   localparam int MAX_FIELD_BYTES = 8;
   localparam int QUEUE_DEPTH     = 2;   // power of two, pointers wrap naturally
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = QUEUE_PTR_W + 1;
   localparam logic [7:0] SPC_RESET = 8'd8;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_LENGTH,
      PHASE_OFFSET
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_RUN,
      STATUS_END,
      STATUS_BAD_HEADER,
      STATUS_NEG_OFFSET
   } status_type;

   // one result in cluster units, scaled to sectors by the back end
   typedef struct packed {
      status_type  status;
      logic        sparse;
      logic [62:0] start_clusters;
      logic [63:0] count_clusters;
   } rld_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rld_queue_status_type;

endpackage

[rtl/rld_req_if.sv]
interface rld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       list_start;

   modport source (output valid, output data_byte, output list_start, input ready);
   modport sink (input valid, input data_byte, input list_start, output ready);
endinterface

[rtl/rld_rsp_if.sv]
interface rld_rsp_if;
   logic        valid;
   logic        ready;
   logic [62:0] start_sector;
   logic [63:0] run_sectors;
   logic        sparse_run;
   logic [1:0]  status;

   modport source (output valid, output start_sector, output run_sectors,
                   output sparse_run, output status, input ready);
   modport sink (input valid, input start_sector, input run_sectors,
                 input sparse_run, input status, output ready);
endinterface

[rtl/rld_front.sv]
module rld_front (
   input  logic                         clock,
   input  logic                         reset,
   rld_req_if.sink                      req,
   input  rld_pkg::rld_queue_status_type q_status,
   output logic                         push,
   output rld_pkg::rld_job_type         push_job
);

   rld_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [3:0]  bytes_left_ff, bytes_left_in;
   logic [3:0]  off_cnt_ff, off_cnt_in;
   logic [2:0]  byte_pos_ff, byte_pos_in;
   logic [63:0] len_acc_ff, len_acc_in;
   logic [63:0] off_acc_ff, off_acc_in;
   logic [63:0] abs_ff, abs_in, cur_abs;
   logic [63:0] total_ff, total_in, cur_total;
   logic        halted_ff, halted_in, cur_halted;

   logic        accept;
   logic [7:0]  b;
   logic [3:0]  len_n, off_n;
   logic [3:0]  bytes_dec;
   logic [63:0] len_new, off_new, sext_mask, off_full;
   logic [63:0] fin_len, rel, abs_sum, total_sum;
   logic        fin_sparse;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;
   assign len_n     = b[3:0];
   assign off_n     = b[7:4];
   assign bytes_dec = bytes_left_ff - 4'd1;

   // a list start clears the list state before the byte is decoded
   assign cur_phase  = req.list_start ? rld_pkg::PHASE_HEADER : phase_ff;
   assign cur_abs    = req.list_start ? 64'd0 : abs_ff;
   assign cur_total  = req.list_start ? 64'd0 : total_ff;
   assign cur_halted = req.list_start ? 1'b0 : halted_ff;

   always_comb begin
      len_new = len_acc_ff;
      len_new[{byte_pos_ff, 3'b000} +: 8] = b;
      off_new = off_acc_ff;
      off_new[{byte_pos_ff, 3'b000} +: 8] = b;
   end

   // sign extension from bit 7 of the top offset byte
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         sext_mask[k*8 +: 8] = (b[7] && (4'(k) >= off_cnt_ff)) ? 8'hFF : 8'h00;
      end
   end

   assign off_full   = off_new | sext_mask;
   assign fin_sparse = (off_cnt_ff == 4'd0);
   assign fin_len    = (cur_phase == rld_pkg::PHASE_LENGTH) ? len_new : len_acc_ff;
   assign rel        = (cur_phase == rld_pkg::PHASE_OFFSET) ? off_full : 64'd0;
   assign abs_sum    = cur_abs + rel;
   assign total_sum  = cur_total + fin_len;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      off_cnt_in    = off_cnt_ff;
      byte_pos_in   = byte_pos_ff;
      len_acc_in    = len_acc_ff;
      off_acc_in    = off_acc_ff;
      abs_in        = abs_ff;
      total_in      = total_ff;
      halted_in     = halted_ff;
      push          = 1'b0;
      push_job      = '0;
      if (accept) begin
         phase_in  = cur_phase;
         abs_in    = cur_abs;
         total_in  = cur_total;
         halted_in = cur_halted;
         if (!cur_halted) begin
            unique case (cur_phase)
               rld_pkg::PHASE_HEADER: begin
                  if (b == 8'd0) begin
                     halted_in               = 1'b1;
                     push                    = 1'b1;
                     push_job.status         = rld_pkg::STATUS_END;
                     push_job.count_clusters = cur_total;
                  end else if (len_n == 4'd0 || len_n > 4'(rld_pkg::MAX_FIELD_BYTES) ||
                               off_n > 4'(rld_pkg::MAX_FIELD_BYTES)) begin
                     halted_in       = 1'b1;
                     push            = 1'b1;
                     push_job.status = rld_pkg::STATUS_BAD_HEADER;
                  end else begin
                     off_cnt_in    = off_n;
                     bytes_left_in = len_n;
                     byte_pos_in   = 3'd0;
                     len_acc_in    = 64'd0;
                     off_acc_in    = 64'd0;
                     phase_in      = rld_pkg::PHASE_LENGTH;
                  end
               end
               rld_pkg::PHASE_LENGTH, rld_pkg::PHASE_OFFSET: begin
                  byte_pos_in   = byte_pos_ff + 3'd1;
                  bytes_left_in = bytes_dec;
                  if (cur_phase == rld_pkg::PHASE_LENGTH) begin
                     len_acc_in = len_new;
                  end else begin
                     off_acc_in = off_new;
                  end
                  if (bytes_dec == 4'd0) begin
                     if (cur_phase == rld_pkg::PHASE_LENGTH && !fin_sparse) begin
                        phase_in      = rld_pkg::PHASE_OFFSET;
                        bytes_left_in = off_cnt_ff;
                        byte_pos_in   = 3'd0;
                     end else begin
                        // run complete
                        phase_in = rld_pkg::PHASE_HEADER;
                        total_in = total_sum;
                        abs_in   = abs_sum;
                        push     = 1'b1;
                        if (abs_sum[63]) begin
                           halted_in       = 1'b1;
                           push_job.status = rld_pkg::STATUS_NEG_OFFSET;
                        end else begin
                           push_job.status         = rld_pkg::STATUS_RUN;
                           push_job.sparse         = fin_sparse;
                           push_job.start_clusters = abs_sum[62:0];
                           push_job.count_clusters = fin_len;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = rld_pkg::PHASE_HEADER;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rld_pkg::PHASE_HEADER;
         bytes_left_ff <= 4'd0;
         off_cnt_ff    <= 4'd0;
         byte_pos_ff   <= 3'd0;
         len_acc_ff    <= 64'd0;
         off_acc_ff    <= 64'd0;
         abs_ff        <= 64'd0;
         total_ff      <= 64'd0;
         halted_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         off_cnt_ff    <= off_cnt_in;
         byte_pos_ff   <= byte_pos_in;
         len_acc_ff    <= len_acc_in;
         off_acc_ff    <= off_acc_in;
         abs_ff        <= abs_in;
         total_ff      <= total_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

[rtl/rld_queue.sv]
module rld_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  rld_pkg::rld_job_type          push_job,
   input  logic                          pop,
   output rld_pkg::rld_job_type          head_job,
   output rld_pkg::rld_queue_status_type q_status
);

   rld_pkg::rld_job_type entry_ff [rld_pkg::QUEUE_DEPTH];
   logic [rld_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rld_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rld_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign q_status.full  = (count_ff == rld_pkg::QUEUE_CNT_W'(rld_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push  = push && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/rld_back.sv]
module rld_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [7:0]                   spc,
   input  rld_pkg::rld_job_type         head_job,
   input  rld_pkg::rld_queue_status_type q_status,
   output logic                         pop,
   rld_rsp_if.source                    rsp
);

   logic        out_valid_ff, out_valid_in;
   logic [62:0] start_ff;
   logic [63:0] count_ff;
   logic        sparse_ff;
   logic [1:0]  status_ff;
   logic [62:0] start_prod;
   logic [63:0] count_prod;

   // error jobs carry zero counts, so the products come out zero as well
   assign start_prod = head_job.start_clusters * {55'd0, spc};
   assign count_prod = head_job.count_clusters * {56'd0, spc};

   assign pop = !q_status.empty && (!out_valid_ff || rsp.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         start_ff  <= start_prod;
         count_ff  <= count_prod;
         sparse_ff <= head_job.sparse;
         status_ff <= head_job.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.start_sector = start_ff;
   assign rsp.run_sectors  = count_ff;
   assign rsp.sparse_run   = sparse_ff;
   assign rsp.status       = status_ff;

endmodule

[rtl/run_list_decoder_top.sv]
// channel  dir  payload                                          handshake
// req      in   data_byte[7:0], list_start                       valid/ready
// rsp      out  start_sector[62:0], run_sectors[63:0],
//               sparse_run, status[1:0]                          valid/ready
// csr      in   csr_write_data[7:0] = sectors per cluster        csr_write_enable
//
// one byte per cycle unless the queue is full; a run's result passes through the queue write,
// then the scaling multiply into the output register
// synchronous active-high reset; sectors per cluster resets to 8
// the front parser stalls only when the two-entry queue is full; the queue
// fills when rsp stays not ready, and while it is full every byte waits,
// even one that produces no item
module run_list_decoder_top (
   input  logic       clock,
   input  logic       reset,
   rld_req_if.sink    req,
   rld_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0] spc_ff, spc_in;
   logic                          push, pop;
   rld_pkg::rld_job_type          push_job, head_job;
   rld_pkg::rld_queue_status_type q_status;

   assign spc_in = csr_write_enable ? csr_write_data : spc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff <= rld_pkg::SPC_RESET;
      end else begin
         spc_ff <= spc_in;
      end
   end

   rld_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   rld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   rld_back u_back (
      .clock    (clock),
      .reset    (reset),
      .spc      (spc_ff),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 4;
   localparam int SEGMENT_ITEMS = 200;

   typedef struct {
      logic [62:0]         start_sector;
      logic [63:0]         run_sectors;
      logic                sparse_run;
      rld_pkg::status_type status;
   } run_result_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   rld_req_if req ();
   rld_rsp_if rsp ();

   run_list_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // decoder state as the testbench sees it
   rld_pkg::phase_type parse_state;
   logic [3:0]  remaining;
   logic [3:0]  offset_count;
   logic [2:0]  byte_idx;
   logic [63:0] length_acc;
   logic [63:0] offset_acc;
   logic [63:0] cluster_base;
   logic [63:0] cluster_total;
   logic        stopped;
   logic [7:0]  spc;

   run_result_type expected_runs[$];
   int          error_count;
   int          items_done;
   int          cycle_count;
   logic        sender_idle;
   logic        receiver_idle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   function automatic void clear_list_state();
      parse_state   = rld_pkg::PHASE_HEADER;
      remaining     = '0;
      offset_count  = '0;
      byte_idx      = '0;
      length_acc    = '0;
      offset_acc    = '0;
      cluster_base  = '0;
      cluster_total = '0;
      stopped       = 1'b0;
   endfunction

   function automatic void queue_result(input logic [62:0] start, input logic [63:0] sectors,
                                        input logic sparse, input rld_pkg::status_type st);
      run_result_type r;
      r.start_sector = start;
      r.run_sectors  = sectors;
      r.sparse_run   = sparse;
      r.status       = st;
      expected_runs.push_back(r);
   endfunction

   function automatic void close_run();
      logic        is_sparse;
      logic [63:0] rel;
      is_sparse = (offset_count == 4'd0);
      rel = is_sparse ? 64'd0 : offset_acc;
      parse_state = rld_pkg::PHASE_HEADER;
      cluster_total += length_acc;
      cluster_base  += rel;
      if (cluster_base[63]) begin
         stopped = 1'b1;
         queue_result('0, '0, 1'b0, rld_pkg::STATUS_NEG_OFFSET);
      end else begin
         queue_result(63'(cluster_base * spc), length_acc * spc, is_sparse,
                      rld_pkg::STATUS_RUN);
      end
   endfunction

   // returns 1 when the byte was not ignored by a halted decoder
   function automatic logic decode_byte(input logic [7:0] b, input logic ls);
      logic [3:0] len_n;
      logic [3:0] off_n;
      logic [5:0] shift;
      if (ls)
         clear_list_state();
      if (stopped)
         return 1'b0;
      if (parse_state == rld_pkg::PHASE_HEADER) begin
         len_n = b[3:0];
         off_n = b[7:4];
         if (b == 8'h00) begin
            stopped = 1'b1;
            queue_result('0, cluster_total * spc, 1'b0, rld_pkg::STATUS_END);
         end else if (len_n == 0 || len_n > rld_pkg::MAX_FIELD_BYTES ||
                      off_n > rld_pkg::MAX_FIELD_BYTES) begin
            stopped = 1'b1;
            queue_result('0, '0, 1'b0, rld_pkg::STATUS_BAD_HEADER);
         end else begin
            offset_count = off_n;
            remaining    = len_n;
            byte_idx     = '0;
            length_acc   = '0;
            offset_acc   = '0;
            parse_state  = rld_pkg::PHASE_LENGTH;
         end
         return 1'b1;
      end
      shift     = {byte_idx, 3'b000};
      byte_idx  = byte_idx + 3'd1;
      remaining = remaining - 4'd1;
      if (parse_state == rld_pkg::PHASE_LENGTH) begin
         length_acc |= 64'(b) << shift;
         if (remaining == 4'd0) begin
            if (offset_count == 4'd0) begin
               close_run();
            end else begin
               parse_state = rld_pkg::PHASE_OFFSET;
               remaining   = offset_count;
               byte_idx    = '0;
            end
         end
      end else begin
         offset_acc |= 64'(b) << shift;
         if (remaining == 4'd0) begin
            // sign extension from the top offset byte
            if (offset_count < 4'd8 && b[7])
               offset_acc |= ~64'd0 << {offset_count, 3'b000};
            close_run();
         end
      end
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic ls);
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.data_byte  <= b;
      req.list_start <= ls;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      if (decode_byte(b, ls))
         items_done++;
   endtask

   // first byte opens a new list
   task automatic send_list(input logic [7:0] seq[$]);
      foreach (seq[i])
         send_byte(seq[i], i == 0);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_runs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_sectors_per_cluster(input logic [7:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      spc = value;
   endtask

   task automatic send_random_list();
      int         run_total;
      int         len_n;
      int         off_n;
      int         mode;
      logic [7:0] b;
      logic       restart;
      run_total = $urandom_range(0, 5);
      mode      = $urandom_range(0, 19);
      restart   = 1'b1;
      for (int r = 0; r < run_total; r++) begin
         len_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
         off_n = $urandom_range(0, 8);
         if (mode == 0 && $urandom_range(0, 2) == 0)
            b = 8'($urandom_range(0, 255));
         else
            b = {4'(off_n), 4'(len_n)};
         send_byte(b, restart);
         restart = 1'b0;
         for (int i = 0; i < len_n; i++)
            send_byte(8'($urandom_range(0, 255)), mode == 1 && $urandom_range(0, 7) == 0);
         for (int i = 0; i < off_n; i++) begin
            b = 8'($urandom_range(0, 255));
            // keep most offsets positive so lists run deep
            if (i == off_n - 1 && $urandom_range(0, 3) != 0)
               b[7] = 1'b0;
            send_byte(b, 1'b0);
         end
      end
      if (mode != 2)
         send_byte(8'h00, restart);
      if (mode == 3)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic test_directed_runs();
      // positive run, sparse run, then an offset that drives the base negative
      send_list({8'h11, 8'hff, 8'h7f, 8'h01, 8'h00, 8'h11, 8'h05, 8'h80, 8'h00});
      // widest length field, then end of list with the total
      send_list({8'h18, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                 8'h01, 8'h00});
      drain();
   endtask

   task automatic test_bad_headers();
      send_list({8'h09});
      send_list({8'h80});
      send_list({8'h91});
      // new list in the middle of a run
      send_list({8'h11, 8'h22});
      send_list({8'h00});
      drain();
   endtask

   task automatic test_cluster_sizes();
      logic [7:0] sizes[4] = '{8'd1, 8'd128, 8'd255, 8'd0};
      foreach (sizes[i]) begin
         set_sectors_per_cluster(sizes[i]);
         repeat (3) send_random_list();
      end
      drain();
   endtask

   task automatic test_random_lists();
      int target;
      for (int seg = 0; seg < 7; seg++) begin
         set_sectors_per_cluster(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                              : 8'($urandom_range(1, 128)));
         sender_idle   = (seg < 6) && (seg % 3 != 2);
         receiver_idle = (seg < 6) && (seg % 3 != 1);
         target = items_done + SEGMENT_ITEMS;
         while (items_done < target)
            send_random_list();
         drain();
      end
   endtask

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch in %s: expected %h, got %h", field, want, got);
   endtask

   always @(posedge clock) begin
      run_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_runs.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("item with nothing pending: status %0d start %h sectors %h",
                        rsp.status, rsp.start_sector, rsp.run_sectors);
         end else begin
            want = expected_runs.pop_front();
            if (rsp.status !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp.status));
            if (rsp.start_sector !== want.start_sector)
               note_mismatch("start_sector", 64'(want.start_sector), 64'(rsp.start_sector));
            if (rsp.run_sectors !== want.run_sectors)
               note_mismatch("run_sectors", want.run_sectors, rsp.run_sectors);
            if (rsp.sparse_run !== want.sparse_run)
               note_mismatch("sparse_run", 64'(want.sparse_run), 64'(rsp.sparse_run));
         end
      end
   end

   always begin
      @(posedge clock);
      if (receiver_idle && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      rsp.ready <= 1'b1;
   end

   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.data_byte    = '0;
      req.list_start   = 1'b0;
      rsp.ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      error_count      = 0;
      items_done       = 0;
      cycle_count      = 0;
      sender_idle      = 1'b1;
      receiver_idle    = 1'b1;
      spc              = rld_pkg::SPC_RESET;
      clear_list_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_runs();
      test_bad_headers();
      test_cluster_sizes();
      test_random_lists();

      drain();
      if (error_count == 0 && expected_runs.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
